### hw/rtl/fpd_pkg.sv
// Shared types and constants for the flight phase detector.
// Used by fpd_timer, fpd_phase_fsm, flight_phase_detector_core and the testbench; depends on nothing else.
package fpd_pkg;

    // The interval registers are always 32 bits wide.
    localparam int INTERVAL_BITS = 32;
    // Configuration data is as wide as the widest register.
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int TICK_BITS = 16;
    localparam int PHASE_BITS = 3;
    // Result item: phase and phase_changed, padded to one byte.
    localparam int OUT_DATA_BITS = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TERMINAL_ALT   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LANDED_DZ      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DESCENT_IVL    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LANDING_IVL    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SILENCE_IVL    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RECOVERED_IVL  = 3'd5;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_STAGING    = 3'd0,
        PH_TAKEOFF    = 3'd1,
        PH_ASCENDING  = 3'd2,
        PH_DESCENDING = 3'd3,
        PH_LANDING    = 3'd4,
        PH_RECOVERY   = 3'd5,
        PH_RECOVERED  = 3'd6
    } fpd_phase_t;

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] descent;
        logic [INTERVAL_BITS-1:0] landing;
        logic [INTERVAL_BITS-1:0] silence;
        logic [INTERVAL_BITS-1:0] recovered;
    } fpd_intervals_t;

endpackage

### hw/rtl/fpd_timer.sv
// One step of a saturating tick accumulator with its interval compare.
// Shared by the four phase timers; uses fpd_pkg for the tick and interval widths.
module fpd_timer #(
    parameter int TIMER_BITS = 32
) (
    input  logic                               running,
    input  logic [TIMER_BITS-1:0]              count,
    input  logic [fpd_pkg::TICK_BITS-1:0]      ticks,
    input  logic [fpd_pkg::INTERVAL_BITS-1:0]  interval,
    output logic                               running_next,
    output logic [TIMER_BITS-1:0]              count_next,
    output logic                               fire
);

    localparam int SUM_BITS =
        ((TIMER_BITS > fpd_pkg::TICK_BITS) ? TIMER_BITS : fpd_pkg::TICK_BITS) + 1;
    localparam int CMP_BITS =
        (TIMER_BITS > fpd_pkg::INTERVAL_BITS) ? TIMER_BITS : fpd_pkg::INTERVAL_BITS;

    logic [SUM_BITS-1:0]   sum;
    logic [TIMER_BITS-1:0] count_sat;

    assign sum = SUM_BITS'(count) + SUM_BITS'(ticks);
    // Anything above the top counter bit means the count saturates.
    assign count_sat = (|sum[SUM_BITS-1:TIMER_BITS]) ? '1 : sum[TIMER_BITS-1:0];

    always_comb begin
        if (!running) begin
            // A stopped timer starts from zero and cannot fire on this item.
            running_next = 1'b1;
            count_next   = '0;
            fire         = 1'b0;
        end else if (CMP_BITS'(count_sat) >= CMP_BITS'(interval)) begin
            running_next = 1'b0;
            count_next   = '0;
            fire         = 1'b1;
        end else begin
            running_next = 1'b1;
            count_next   = count_sat;
            fire         = 1'b0;
        end
    end

endmodule

### hw/rtl/fpd_phase_fsm.sv
// Phase state machine: current phase, last altitude and the four timers.
// Uses fpd_pkg and one shared fpd_timer step unit.
module fpd_phase_fsm #(
    parameter int ALTITUDE_BITS = 18,
    parameter int TIMER_BITS    = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_valid,
    input  logic signed [ALTITUDE_BITS-1:0]     altitude,
    input  logic                                launch_armed,
    input  logic                                silence_held,
    input  logic [fpd_pkg::TICK_BITS-1:0]       elapsed_ticks,
    input  logic signed [ALTITUDE_BITS-1:0]     alt_threshold,
    input  logic [ALTITUDE_BITS-2:0]            landed_deadzone,
    input  fpd_pkg::fpd_intervals_t             intervals,
    output logic [fpd_pkg::PHASE_BITS-1:0]      phase_next,
    output logic                                phase_changed
);

    typedef enum logic [1:0] {
        TMR_DESCENT   = 2'd0,
        TMR_LANDING   = 2'd1,
        TMR_SILENCE   = 2'd2,
        TMR_RECOVERED = 2'd3
    } tmr_sel_t;

    // Two extra bits hold last_altitude plus or minus the deadzone.
    localparam int WIDE_BITS = ALTITUDE_BITS + 2;

    fpd_pkg::fpd_phase_t              phase_reg, phase_calc;
    logic signed [ALTITUDE_BITS-1:0]  last_alt_reg, last_alt_next;
    logic [3:0]                       tmr_running_reg, tmr_running_next;
    logic [TIMER_BITS-1:0]            tmr_count_reg [4];
    logic [TIMER_BITS-1:0]            tmr_count_next [4];

    tmr_sel_t                         tmr_sel;
    logic                             tmr_run;
    logic                             tmr_clear;
    logic [fpd_pkg::INTERVAL_BITS-1:0] tmr_interval;
    logic                             tu_running_next;
    logic [TIMER_BITS-1:0]            tu_count_next;
    logic                             tu_fire;

    logic signed [WIDE_BITS-1:0]      alt_w, last_w, dz_w;
    logic                             in_band;

    assign alt_w   = WIDE_BITS'(altitude);
    assign last_w  = WIDE_BITS'(last_alt_reg);
    assign dz_w    = WIDE_BITS'($signed({1'b0, landed_deadzone}));
    assign in_band = (alt_w <= last_w + dz_w) && (alt_w >= last_w - dz_w);

    always_comb begin
        case (tmr_sel)
            TMR_DESCENT:   tmr_interval = intervals.descent;
            TMR_LANDING:   tmr_interval = intervals.landing;
            TMR_SILENCE:   tmr_interval = intervals.silence;
            TMR_RECOVERED: tmr_interval = intervals.recovered;
            default:       tmr_interval = intervals.recovered;
        endcase
    end

    fpd_timer #(
        .TIMER_BITS (TIMER_BITS)
    ) u_timer (
        .running      (tmr_running_reg[tmr_sel]),
        .count        (tmr_count_reg[tmr_sel]),
        .ticks        (elapsed_ticks),
        .interval     (tmr_interval),
        .running_next (tu_running_next),
        .count_next   (tu_count_next),
        .fire         (tu_fire)
    );

    // Only the rule of the current phase is evaluated.
    always_comb begin
        phase_calc    = phase_reg;
        last_alt_next = last_alt_reg;
        tmr_sel       = TMR_DESCENT;
        tmr_run       = 1'b0;
        tmr_clear     = 1'b0;
        case (phase_reg)
            fpd_pkg::PH_STAGING: begin
                if (launch_armed) phase_calc = fpd_pkg::PH_TAKEOFF;
            end
            fpd_pkg::PH_TAKEOFF: begin
                if (!launch_armed) begin
                    phase_calc = fpd_pkg::PH_STAGING;
                end else if (altitude >= alt_threshold) begin
                    phase_calc = fpd_pkg::PH_ASCENDING;
                end
            end
            fpd_pkg::PH_ASCENDING: begin
                tmr_sel       = TMR_DESCENT;
                tmr_run       = (altitude < last_alt_reg);
                tmr_clear     = !tmr_run;
                last_alt_next = altitude;
                if (tmr_run && tu_fire) phase_calc = fpd_pkg::PH_DESCENDING;
            end
            fpd_pkg::PH_DESCENDING: begin
                if (altitude <= alt_threshold) phase_calc = fpd_pkg::PH_LANDING;
            end
            fpd_pkg::PH_LANDING: begin
                tmr_sel       = TMR_LANDING;
                tmr_run       = in_band;
                tmr_clear     = !in_band;
                last_alt_next = altitude;
                if (tmr_run && tu_fire) phase_calc = fpd_pkg::PH_RECOVERY;
            end
            fpd_pkg::PH_RECOVERY: begin
                tmr_sel   = TMR_SILENCE;
                tmr_run   = silence_held;
                tmr_clear = !silence_held;
                if (tmr_run && tu_fire) phase_calc = fpd_pkg::PH_RECOVERED;
            end
            fpd_pkg::PH_RECOVERED: begin
                tmr_sel = TMR_RECOVERED;
                tmr_run = 1'b1;
                if (tu_fire) phase_calc = fpd_pkg::PH_RECOVERY;
            end
            default: begin
                phase_calc = phase_reg;
            end
        endcase
    end

    always_comb begin
        tmr_running_next = tmr_running_reg;
        for (int i = 0; i < 4; i++) begin
            tmr_count_next[i] = tmr_count_reg[i];
        end
        if (tmr_run) begin
            tmr_running_next[tmr_sel] = tu_running_next;
            tmr_count_next[tmr_sel]   = tu_count_next;
        end else if (tmr_clear) begin
            tmr_running_next[tmr_sel] = 1'b0;
            tmr_count_next[tmr_sel]   = '0;
        end
    end

    assign phase_next    = phase_calc;
    assign phase_changed = (phase_calc != phase_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= fpd_pkg::PH_STAGING;
            last_alt_reg    <= '0;
            tmr_running_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                tmr_count_reg[i] <= '0;
            end
        end else if (step_valid) begin
            phase_reg       <= phase_calc;
            last_alt_reg    <= last_alt_next;
            tmr_running_reg <= tmr_running_next;
            for (int i = 0; i < 4; i++) begin
                tmr_count_reg[i] <= tmr_count_next[i];
            end
        end
    end

    // A timed phase is left only when its timer fires and stops, so at most one timer runs.
    a_one_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tmr_running_reg))
        else $error("more than one phase timer running");

    a_descent_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        tmr_running_reg[TMR_DESCENT] |-> phase_reg == fpd_pkg::PH_ASCENDING)
        else $error("descent timer running outside ascending");

    a_recovered_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        tmr_running_reg[TMR_RECOVERED] |-> phase_reg == fpd_pkg::PH_RECOVERED)
        else $error("recovered timer running outside recovered");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !tmr_running_reg[TMR_LANDING] |-> tmr_count_reg[TMR_LANDING] == '0)
        else $error("stopped landing timer holds a count");

endmodule

### hw/rtl/flight_phase_detector_core.sv
// Top level of the flight phase detector: stream ports, configuration
// registers, input and result registers. Uses fpd_pkg, fpd_phase_fsm, fpd_timer.
//
// Usage: each input item on the s_ channel carries one altitude sample, the
// launch and silence switches and the ticks elapsed since the previous item.
// For every accepted item exactly one result item leaves on the m_ channel
// with the phase after that item and a flag set when the phase changed.
// Items are accepted on cycles where s_tvalid and s_tready are both high,
// results are taken where m_tvalid and m_tready are both high.
// An accepted item first loads the input register; the phase rule and the shared
// timer step then load the result register, which drives m_tvalid, once the
// result register is empty or being taken. Throughput is one item per cycle while
// the receiver does not stall.
// When the receiver stalls, the result register holds its item and the input
// register holds one more; s_tready then drops until m_tready returns.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must write them only while no item is in flight, which the block does not enforce.
// A synchronous low aresetn returns the phase to staging, clears the timers and last
// altitude, loads the register defaults and empties both item registers.
module flight_phase_detector_core #(
    parameter int ALTITUDE_BITS = 18,
    parameter int TIMER_BITS    = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Fields from bit 0: altitude, launch_armed, silence_held, elapsed_ticks, zero pad.
    input  logic [((ALTITUDE_BITS + fpd_pkg::TICK_BITS + 9) / 8) * 8 - 1:0] s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: phase, phase_changed, zero pad.
    output logic [fpd_pkg::OUT_DATA_BITS-1:0]     m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_wr_en,
    input  logic [fpd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [fpd_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

    localparam int OUT_PAD_BITS  = fpd_pkg::OUT_DATA_BITS - fpd_pkg::PHASE_BITS - 1;

    // Configuration registers.
    logic signed [ALTITUDE_BITS-1:0]  terminal_alt_reg;
    logic [ALTITUDE_BITS-2:0]         deadzone_reg;
    fpd_pkg::fpd_intervals_t          intervals_reg;

    // Input register.
    logic                             in_valid_reg;
    logic signed [ALTITUDE_BITS-1:0]  altitude_reg;
    logic                             launch_reg;
    logic                             silence_reg;
    logic [fpd_pkg::TICK_BITS-1:0]    ticks_reg;

    // Result register.
    logic                             out_valid_reg;
    logic [fpd_pkg::PHASE_BITS-1:0]   phase_reg;
    logic                             changed_reg;

    logic                             step_go;
    logic                             s_accept;
    logic [fpd_pkg::PHASE_BITS-1:0]   phase_next;
    logic                             changed_next;

    assign step_go  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_go;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            terminal_alt_reg        <= ALTITUDE_BITS'(1000);
            deadzone_reg            <= (ALTITUDE_BITS-1)'(5);
            intervals_reg.descent   <= 32'd10000;
            intervals_reg.landing   <= 32'd10000;
            intervals_reg.silence   <= 32'd5000;
            intervals_reg.recovered <= 32'd600000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fpd_pkg::CFG_TERMINAL_ALT:  terminal_alt_reg <= cfg_wdata[ALTITUDE_BITS-1:0];
                fpd_pkg::CFG_LANDED_DZ:     deadzone_reg <= cfg_wdata[ALTITUDE_BITS-2:0];
                fpd_pkg::CFG_DESCENT_IVL:   intervals_reg.descent <= cfg_wdata;
                fpd_pkg::CFG_LANDING_IVL:   intervals_reg.landing <= cfg_wdata;
                fpd_pkg::CFG_SILENCE_IVL:   intervals_reg.silence <= cfg_wdata;
                fpd_pkg::CFG_RECOVERED_IVL: intervals_reg.recovered <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (step_go) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            altitude_reg <= s_tdata[ALTITUDE_BITS-1:0];
            launch_reg   <= s_tdata[ALTITUDE_BITS];
            silence_reg  <= s_tdata[ALTITUDE_BITS+1];
            ticks_reg    <= s_tdata[ALTITUDE_BITS+2 +: fpd_pkg::TICK_BITS];
        end
    end

    fpd_phase_fsm #(
        .ALTITUDE_BITS (ALTITUDE_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_fsm (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step_valid        (step_go),
        .altitude          (altitude_reg),
        .launch_armed      (launch_reg),
        .silence_held      (silence_reg),
        .elapsed_ticks     (ticks_reg),
        .alt_threshold     (terminal_alt_reg),
        .landed_deadzone   (deadzone_reg),
        .intervals         (intervals_reg),
        .phase_next        (phase_next),
        .phase_changed     (changed_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_go) begin
            phase_reg   <= phase_next;
            changed_reg <= changed_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_BITS{1'b0}}, changed_reg, phase_reg};

endmodule

### tb/phase_checker.sv
// Checker for flight_phase_detector_core: watches the item, result and register ports,
// keeps its own copy of the phase rules and compares every result item. Depends on fpd_pkg.
module phase_checker #(
    parameter int ALT_BITS = 18,
    parameter int IN_BITS  = 40
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [IN_BITS-1:0]                 s_tdata,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [fpd_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_wr_en,
    input  logic [fpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [fpd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output fpd_pkg::fpd_phase_t                flight_phase,
    output int                                 backlog,
    output int                                 mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DESCENT_TMR   = 0;
    localparam int LANDING_TMR   = 1;
    localparam int SILENCE_TMR   = 2;
    localparam int RECOVERED_TMR = 3;

    typedef struct packed {
        fpd_pkg::fpd_phase_t phase;
        logic                changed;
    } phase_report_t;

    logic signed [ALT_BITS-1:0]        terminal_alt;
    logic [ALT_BITS-2:0]               deadzone;
    logic [fpd_pkg::INTERVAL_BITS-1:0] timer_limit [4];
    logic signed [ALT_BITS-1:0]        prev_alt;
    logic                              timer_on [4];
    logic [fpd_pkg::INTERVAL_BITS-1:0] timer_cnt [4];
    phase_report_t                     reports_due [$];
    phase_report_t                     want;

    function automatic void clear_timer(int t);
        timer_on[t] = 1'b0;
        timer_cnt[t] = '0;
    endfunction

    // A stopped timer only starts on this item; a running one adds the ticks,
    // saturating, and fires once its limit is reached.
    function automatic logic run_timer(int t, logic [fpd_pkg::TICK_BITS-1:0] ticks);
        logic [fpd_pkg::INTERVAL_BITS:0] sum;
        if (!timer_on[t]) begin
            timer_on[t] = 1'b1;
            timer_cnt[t] = '0;
            return 1'b0;
        end
        sum = {1'b0, timer_cnt[t]}
              + {{(fpd_pkg::INTERVAL_BITS + 1 - fpd_pkg::TICK_BITS){1'b0}}, ticks};
        timer_cnt[t] = sum[fpd_pkg::INTERVAL_BITS] ? '1 : sum[fpd_pkg::INTERVAL_BITS-1:0];
        if (timer_cnt[t] >= timer_limit[t]) begin
            clear_timer(t);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic phase_report_t next_phase(logic [IN_BITS-1:0] item);
        logic signed [ALT_BITS-1:0]     alt;
        logic                           launch;
        logic                           silence;
        logic [fpd_pkg::TICK_BITS-1:0]  ticks;
        fpd_pkg::fpd_phase_t            next;
        longint                         upper;
        longint                         lower;
        phase_report_t                  r;
        alt = item[ALT_BITS-1:0];
        launch = item[ALT_BITS];
        silence = item[ALT_BITS+1];
        ticks = item[ALT_BITS+2 +: fpd_pkg::TICK_BITS];
        next = flight_phase;
        case (flight_phase)
            fpd_pkg::PH_STAGING: begin
                if (launch) next = fpd_pkg::PH_TAKEOFF;
            end
            fpd_pkg::PH_TAKEOFF: begin
                if (!launch) next = fpd_pkg::PH_STAGING;
                else if (alt >= terminal_alt) next = fpd_pkg::PH_ASCENDING;
            end
            fpd_pkg::PH_ASCENDING: begin
                if (alt < prev_alt) begin
                    if (run_timer(DESCENT_TMR, ticks)) next = fpd_pkg::PH_DESCENDING;
                end else begin
                    clear_timer(DESCENT_TMR);
                end
                prev_alt = alt;
            end
            fpd_pkg::PH_DESCENDING: begin
                if (alt <= terminal_alt) next = fpd_pkg::PH_LANDING;
            end
            fpd_pkg::PH_LANDING: begin
                upper = longint'(prev_alt) + longint'(deadzone);
                lower = longint'(prev_alt) - longint'(deadzone);
                if (alt <= upper && alt >= lower) begin
                    if (run_timer(LANDING_TMR, ticks)) next = fpd_pkg::PH_RECOVERY;
                end else begin
                    clear_timer(LANDING_TMR);
                end
                prev_alt = alt;
            end
            fpd_pkg::PH_RECOVERY: begin
                if (silence) begin
                    if (run_timer(SILENCE_TMR, ticks)) next = fpd_pkg::PH_RECOVERED;
                end else begin
                    clear_timer(SILENCE_TMR);
                end
            end
            fpd_pkg::PH_RECOVERED: begin
                if (run_timer(RECOVERED_TMR, ticks)) next = fpd_pkg::PH_RECOVERY;
            end
            default: ;
        endcase
        r.phase = next;
        r.changed = (next != flight_phase);
        flight_phase = next;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            terminal_alt = ALT_BITS'(1000);
            deadzone = (ALT_BITS-1)'(5);
            timer_limit[DESCENT_TMR] = 32'd10000;
            timer_limit[LANDING_TMR] = 32'd10000;
            timer_limit[SILENCE_TMR] = 32'd5000;
            timer_limit[RECOVERED_TMR] = 32'd600000;
            flight_phase = fpd_pkg::PH_STAGING;
            prev_alt = '0;
            for (int t = 0; t < 4; t++) clear_timer(t);
            reports_due.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reports_due.size() == 0) begin
                    $error("result item with no item pending: phase %0d",
                           m_tdata[fpd_pkg::PHASE_BITS-1:0]);
                    mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    if (m_tdata[fpd_pkg::PHASE_BITS-1:0] != want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase,
                               m_tdata[fpd_pkg::PHASE_BITS-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[fpd_pkg::PHASE_BITS] != want.changed) begin
                        $error("phase_changed: expected %0d, got %0d", want.changed,
                               m_tdata[fpd_pkg::PHASE_BITS]);
                        mismatches++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    fpd_pkg::CFG_TERMINAL_ALT:  terminal_alt = cfg_wdata[ALT_BITS-1:0];
                    fpd_pkg::CFG_LANDED_DZ:     deadzone = cfg_wdata[ALT_BITS-2:0];
                    fpd_pkg::CFG_DESCENT_IVL:   timer_limit[DESCENT_TMR] = cfg_wdata;
                    fpd_pkg::CFG_LANDING_IVL:   timer_limit[LANDING_TMR] = cfg_wdata;
                    fpd_pkg::CFG_SILENCE_IVL:   timer_limit[SILENCE_TMR] = cfg_wdata;
                    fpd_pkg::CFG_RECOVERED_IVL: timer_limit[RECOVERED_TMR] = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) reports_due.push_back(next_phase(s_tdata));
        end
        backlog = reports_due.size();
    end

endmodule

### tb/testbench.sv
// Top of the flight_phase_detector_core testbench: clock, reset, item and register stimulus
// that flies one full balloon flight, and the verdict. Depends on fpd_pkg and phase_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ALT_BITS = 18;
    localparam int IN_BITS = 40;
    localparam int TICK_W = fpd_pkg::TICK_BITS;
    localparam logic signed [ALT_BITS-1:0] ALT_MAX = ALT_BITS'(131071);
    localparam logic signed [ALT_BITS-1:0] ALT_MIN = ALT_BITS'(-131072);
    localparam int WATCHDOG_LIMIT = 5000;
    // Indexes past the last register; writes to them must change nothing.
    localparam logic [fpd_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [fpd_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_B = 3'd7;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_SLOW
    } ready_style_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    // Fields from bit 0: altitude, launch_armed, silence_held, elapsed_ticks, zero pad.
    logic [IN_BITS-1:0]                  s_tdata = '0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    // Fields from bit 0: phase, phase_changed, zero pad.
    logic [fpd_pkg::OUT_DATA_BITS-1:0]   m_tdata;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [fpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [fpd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata = '0;

    fpd_pkg::fpd_phase_t        flight_phase;
    int                         backlog;
    int                         mismatches;

    logic signed [ALT_BITS-1:0] cur_alt;
    int                         burst_left;
    ready_style_t               ready_style = READY_ALWAYS;
    int                         style_left = 0;
    int                         cycle_no = 0;
    int                         quiet_cycles = 0;

    flight_phase_detector_core #(
        .ALTITUDE_BITS(ALT_BITS),
        .TIMER_BITS   (32)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    phase_checker #(
        .ALT_BITS(ALT_BITS),
        .IN_BITS (IN_BITS)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .flight_phase(flight_phase),
        .backlog     (backlog),
        .mismatches  (mismatches)
    );

    always #10 aclk = ~aclk;

    // The receiver switches between stall styles, holding each for a random stretch.
    always @(negedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (style_left == 0) begin
            ready_style <= ready_style_t'($urandom_range(0, 3));
            style_left <= $urandom_range(50, 400);
        end else begin
            style_left <= style_left - 1;
        end
        case (ready_style)
            READY_ALWAYS:   m_tready <= 1'b1;
            READY_RANDOM:   m_tready <= ($urandom_range(0, 9) < 7);
            READY_PERIODIC: m_tready <= ((cycle_no % 7) < 2);
            default:        m_tready <= ($urandom_range(0, 19) == 0) ? ~m_tready : m_tready;
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic odds(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic signed [ALT_BITS-1:0] rand_alt();
        return ALT_BITS'($urandom);
    endfunction

    function automatic logic [TICK_W-1:0] rand_ticks();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return TICK_W'($urandom_range(0, 64));
            default: return TICK_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [ALT_BITS-1:0] clamp_alt(int v);
        if (v > ALT_MAX) return ALT_MAX;
        if (v < ALT_MIN) return ALT_MIN;
        return v[ALT_BITS-1:0];
    endfunction

    // Small random climbs and drops, with level stretches and the odd wild sample.
    function automatic logic signed [ALT_BITS-1:0] climb_step();
        case ($urandom_range(0, 19))
            0, 1:                   return rand_alt();
            2, 3, 4:                return cur_alt;
            5, 6, 7, 8, 9, 10, 11:  return clamp_alt(cur_alt + int'($urandom_range(1, 400)));
            default:                return clamp_alt(cur_alt - int'($urandom_range(1, 400)));
        endcase
    endfunction

    // Altitude near the previous sample: inside the band, on its edges, just past it,
    // or far away.
    function automatic logic signed [ALT_BITS-1:0] drift_alt(int dz);
        case ($urandom_range(0, 11))
            0:       return rand_alt();
            1:       return (cur_alt >= 0) ? ALT_MIN : ALT_MAX;
            2:       return clamp_alt(cur_alt + dz + 1 + int'($urandom_range(0, 50)));
            3:       return clamp_alt(cur_alt - dz - 1 - int'($urandom_range(0, 50)));
            4:       return clamp_alt(cur_alt + dz);
            5:       return clamp_alt(cur_alt - dz);
            default: return clamp_alt(cur_alt + int'($urandom_range(0, 2 * dz)) - dz);
        endcase
    endfunction

    task automatic send(logic signed [ALT_BITS-1:0] alt, logic launch, logic silence,
                        logic [TICK_W-1:0] ticks);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = odds(25) ? $urandom_range(40, 120) : $urandom_range(1, 12);
        end
        s_tdata <= {{(IN_BITS - ALT_BITS - 2 - TICK_W){1'b0}}, ticks, silence, launch, alt};
        s_tvalid <= 1'b1;
        cur_alt = alt;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        @(negedge aclk);
    endtask

    // Registers change only once every result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (backlog != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(logic [fpd_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [fpd_pkg::CFG_DATA_BITS-1:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_terminal(logic signed [ALT_BITS-1:0] alt);
        write_reg(fpd_pkg::CFG_TERMINAL_ALT,
                  {{(fpd_pkg::CFG_DATA_BITS - ALT_BITS){1'b0}}, alt});
    endtask

    initial begin
        logic signed [ALT_BITS-1:0] ground_thr [3];
        logic signed [ALT_BITS-1:0] alt;
        int                         dz;
        int                         n;
        burst_left = 0;
        cur_alt = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Register defaults: launch toggles between staging and takeoff, 999 stays below
        // the default terminal altitude.
        send(ALT_MIN, 1'b0, 1'b1, '1);
        send(ALT_MAX, 1'b0, 1'b0, '0);
        send(ALT_BITS'(0), 1'b0, 1'b1, 16'd1234);
        send(ALT_BITS'(500), 1'b1, 1'b0, '0);
        send(ALT_BITS'(999), 1'b1, 1'b1, '1);
        send(ALT_BITS'(-5), 1'b0, 1'b0, 16'd7);
        send(ALT_MIN, 1'b1, 1'b0, '0);
        send(ALT_MIN, 1'b1, 1'b1, 16'd3);
        send(ALT_BITS'(0), 1'b0, 1'b0, '1);
        wait_idle();
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);

        // On the ground the altitude stays below the threshold so the flight cannot start.
        ground_thr[0] = ALT_BITS'($urandom_range(0, 200000) - 100000);
        ground_thr[1] = '0;
        ground_thr[2] = ALT_MAX;
        for (int g = 0; g < 3; g++) begin
            wait_idle();
            set_terminal(ground_thr[g]);
            repeat (120) begin
                alt = rand_alt();
                if (alt >= ground_thr[g])
                    alt = clamp_alt(ground_thr[g] - 1 - int'($urandom_range(0, 500)));
                send(alt, odds(60), odds(50), rand_ticks());
            end
        end
        // The threshold is at its top, so only the exact top altitude lifts off.
        while (flight_phase != fpd_pkg::PH_ASCENDING)
            send(ALT_MAX, 1'b1, odds(50), rand_ticks());

        wait_idle();
        write_reg(fpd_pkg::CFG_DESCENT_IVL, '1);
        repeat (200) send(climb_step(), odds(50), odds(50), rand_ticks());
        wait_idle();
        write_reg(fpd_pkg::CFG_DESCENT_IVL, $urandom_range(20000, 300000));
        for (n = 0; n < 200 && flight_phase == fpd_pkg::PH_ASCENDING; n++)
            send(climb_step(), odds(50), odds(50), rand_ticks());
        wait_idle();
        write_reg(fpd_pkg::CFG_DESCENT_IVL, '0);
        while (flight_phase == fpd_pkg::PH_ASCENDING) begin
            alt = (cur_alt < ALT_MIN + 400) ? ALT_MAX
                                             : clamp_alt(cur_alt - int'($urandom_range(1, 300)));
            send(alt, odds(50), odds(50), rand_ticks());
        end

        // Descent against the lowest terminal altitude: only the bottom value lands.
        wait_idle();
        set_terminal(ALT_MIN);
        repeat (60) begin
            alt = odds(15) ? ALT_BITS'(ALT_MIN + 1) : rand_alt();
            if (alt == ALT_MIN) alt = ALT_BITS'(ALT_MIN + 1);
            send(alt, odds(50), odds(50), rand_ticks());
        end
        while (flight_phase == fpd_pkg::PH_DESCENDING)
            send(ALT_MIN, odds(50), odds(50), rand_ticks());

        // Landing: first the deadzone extremes with a timer that never fires.
        wait_idle();
        write_reg(fpd_pkg::CFG_LANDING_IVL, '1);
        write_reg(fpd_pkg::CFG_LANDED_DZ, '0);
        repeat (100) send(drift_alt(0), odds(50), odds(50), rand_ticks());
        wait_idle();
        write_reg(fpd_pkg::CFG_LANDED_DZ, {{(fpd_pkg::CFG_DATA_BITS - ALT_BITS){1'b0}}, ALT_MAX});
        repeat (100) send(drift_alt(int'(ALT_MAX)), odds(50), odds(50), rand_ticks());
        wait_idle();
        dz = $urandom_range(1, 60);
        write_reg(fpd_pkg::CFG_LANDED_DZ, dz);
        write_reg(fpd_pkg::CFG_LANDING_IVL, $urandom_range(30000, 200000));
        for (n = 0; n < 200 && flight_phase == fpd_pkg::PH_LANDING; n++)
            send(drift_alt(dz), odds(50), odds(50), rand_ticks());
        wait_idle();
        write_reg(fpd_pkg::CFG_LANDING_IVL, '0);
        while (flight_phase == fpd_pkg::PH_LANDING)
            send(cur_alt, odds(50), odds(50), rand_ticks());

        // Recovery and recovered alternate; the silence switch is mostly held.
        wait_idle();
        write_reg(fpd_pkg::CFG_SILENCE_IVL, $urandom_range(1000, 100000));
        write_reg(fpd_pkg::CFG_RECOVERED_IVL, $urandom_range(1000, 200000));
        repeat (300) send(rand_alt(), odds(50), odds(75), rand_ticks());
        wait_idle();
        write_reg(fpd_pkg::CFG_SILENCE_IVL, '0);
        write_reg(fpd_pkg::CFG_RECOVERED_IVL, '0);
        repeat (80) send(rand_alt(), odds(50), odds(60), rand_ticks());
        wait_idle();
        write_reg(fpd_pkg::CFG_SILENCE_IVL, '1);
        write_reg(fpd_pkg::CFG_RECOVERED_IVL, $urandom_range(1000, 200000));
        repeat (40) send(rand_alt(), odds(50), odds(75), rand_ticks());

        // A long recovered interval takes a run of full-size tick steps before it fires.
        wait_idle();
        write_reg(fpd_pkg::CFG_SILENCE_IVL, '0);
        write_reg(fpd_pkg::CFG_RECOVERED_IVL, $urandom_range(600000, 1500000));
        while (flight_phase != fpd_pkg::PH_RECOVERED)
            send(rand_alt(), odds(50), 1'b1, rand_ticks());
        while (flight_phase == fpd_pkg::PH_RECOVERED)
            send(rand_alt(), odds(50), odds(50), 16'hFFFF);

        wait_idle();
        write_reg(fpd_pkg::CFG_SILENCE_IVL, $urandom_range(0, 60000));
        write_reg(fpd_pkg::CFG_RECOVERED_IVL, $urandom_range(0, 150000));
        repeat (150) send(rand_alt(), odds(50), odds(70), rand_ticks());

        wait_idle();
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && backlog == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
